// ===== sv/cpb_pkg.sv =====
`timescale 1ns / 1ps
package cpb_pkg;

	localparam logic [1:0] FMT_RGB_LE = 2'd0;
	localparam logic [1:0] FMT_RGB_BE = 2'd1;
	localparam logic [1:0] FMT_GRAY4  = 2'd2;
	localparam logic [1:0] FMT_GRAY8  = 2'd3;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_COLOR  = 2'd1;
	localparam logic [1:0] REG_BLEND  = 2'd2;

	localparam logic [31:0] PACK_MASK  = 32'h07E0F81F;
	localparam logic [31:0] PACK_ROUND = 32'h02008010;
	localparam logic [7:0]  BLEND_OPAQUE = 8'hFF;
	localparam logic [7:0]  COV_FULL     = 8'hFF;
	localparam logic [4:0]  W_FULL       = 5'd31;

	typedef struct packed {
		logic [1:0]  pixel_format;
		logic [15:0] fill_color;
		logic [7:0]  global_blend;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        full;
		logic [7:0]  wt;
		logic [15:0] src;
		logic [15:0] dst;
	} wstage_t;

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [31:0] pack565(input logic [15:0] v);
		return {v, v} & PACK_MASK;
	endfunction

endpackage

// ===== sv/cpb_weight.sv =====
`timescale 1ns / 1ps
module cpb_weight (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [15:0]        old_pixel,
	input  logic [7:0]         coverage,
	input  cpb_pkg::cfg_t      cfg,
	output cpb_pkg::wstage_t   st_s2
);
	import cpb_pkg::*;

	logic        v_s1;
	logic [15:0] old_s1;
	logic [7:0]  cov_s1;
	logic [15:0] prod_s1;

	logic        opaque;
	logic [4:0]  w5;
	wstage_t     nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			old_s1  <= old_pixel;
			cov_s1  <= coverage;
			prod_s1 <= {8'h00, coverage} * {8'h00, cfg.global_blend};
		end
	end

	always_comb begin
		opaque    = (cfg.global_blend == BLEND_OPAQUE);
		w5        = opaque ? cov_s1[7:3] : prod_s1[15:11];
		nxt.valid = v_s1;
		nxt.full  = opaque && (cov_s1 == COV_FULL);
		nxt.wt    = {3'b000, w5};
		nxt.src   = cfg.fill_color;
		nxt.dst   = old_s1;
		unique case (cfg.pixel_format)
			FMT_RGB_LE: begin
			end
			FMT_RGB_BE: begin
				nxt.src = swap16(cfg.fill_color);
				nxt.dst = swap16(old_s1);
			end
			FMT_GRAY4: begin
				nxt.wt  = opaque ? cov_s1 : prod_s1[15:8];
				nxt.src = {12'h000, cfg.fill_color[3:0]};
				nxt.dst = {12'h000, old_s1[3:0]};
			end
			FMT_GRAY8: begin
				nxt.full = opaque && (w5 == W_FULL);
				nxt.src  = {8'h00, cfg.fill_color[7:0]};
				nxt.dst  = {8'h00, old_s1[7:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else if (en) begin
			st_s2 <= nxt;
		end
	end

endmodule

// ===== sv/cpb_mix.sv =====
`timescale 1ns / 1ps
module cpb_mix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cpb_pkg::wstage_t   st_s2,
	input  cpb_pkg::cfg_t      cfg,
	output logic               v_s4,
	output logic [15:0]        pix_s4
);
	import cpb_pkg::*;

	logic        v_s3;
	logic        full_s3;
	logic [31:0] t_s3;
	logic [15:0] gsum_s3;

	logic [31:0] ps;
	logic [31:0] pd;
	logic [31:0] diff;
	logic [31:0] t_nxt;
	logic [15:0] gsum_nxt;

	logic [31:0] t_a;
	logic [31:0] t_b;
	logic [15:0] rgb;
	logic [15:0] res;

	always_comb begin
		ps    = pack565(st_s2.src);
		pd    = pack565(st_s2.dst);
		diff  = ps - pd;
		t_nxt = 32'(diff * {27'd0, st_s2.wt[4:0]}) + (pd << 5) - pd + PACK_ROUND;
		if (cfg.pixel_format == FMT_GRAY4) begin
			gsum_nxt = ({12'h000, st_s2.dst[3:0]} * {8'h00, 8'hFF - st_s2.wt})
				+ ({12'h000, st_s2.src[3:0]} * {8'h00, st_s2.wt});
		end else begin
			gsum_nxt = ({8'h00, st_s2.dst[7:0]} * {11'd0, W_FULL - st_s2.wt[4:0]})
				+ ({8'h00, st_s2.src[7:0]} * {11'd0, st_s2.wt[4:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= st_s2.valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s3 <= st_s2.full;
			t_s3    <= t_nxt;
			gsum_s3 <= gsum_nxt;
			pix_s4  <= res;
		end
	end

	always_comb begin
		t_a = t_s3 + ((t_s3 >> 5) & PACK_MASK);
		t_b = (t_a >> 5) & PACK_MASK;
		rgb = t_b[15:0] | t_b[31:16];
		res = rgb;
		unique case (cfg.pixel_format)
			FMT_RGB_LE: res = full_s3 ? cfg.fill_color : rgb;
			FMT_RGB_BE: res = full_s3 ? cfg.fill_color : swap16(rgb);
			FMT_GRAY4:  res = full_s3 ? {12'h000, cfg.fill_color[3:0]}
				: {8'h00, gsum_s3[15:8]};
			FMT_GRAY8:  res = full_s3 ? {8'h00, cfg.fill_color[7:0]}
				: {5'd0, gsum_s3[15:5]};
			default:    res = rgb;
		endcase
	end

endmodule

// ===== sv/coverage_pixel_blend.sv =====
`timescale 1ns / 1ps
// A result passes the stage one to four registers after its input transfer and is held on
// m_tdata by the stage four register until it transfers from there on m_tready.
// Throughput is one pixel per cycle; the whole pipeline holds when a result waits.
// Stage one forms the coverage by blend product, stage two the weights, stage three
// the channel multiply, stage four the rounding and the output register.
// Reset clears the valid bits and sets the registers to RGB565 little endian,
// fill color zero and global blend 255.
module coverage_pixel_blend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // old_pixel [15:0], coverage [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // new_pixel [15:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cpb_pkg::*;

	cfg_t        cfg_q;
	logic        en;
	logic        wr;
	wstage_t     st_s2;
	logic        v_s4;
	logic [15:0] pix_s4;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= FMT_RGB_LE;
			cfg_q.fill_color   <= 16'h0000;
			cfg_q.global_blend <= BLEND_OPAQUE;
		end else if (wr) begin
			case (paddr[3:2])
				REG_FORMAT: cfg_q.pixel_format <= pwdata[1:0];
				REG_COLOR:  cfg_q.fill_color   <= pwdata[15:0];
				REG_BLEND:  cfg_q.global_blend <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FORMAT: prdata = {30'd0, cfg_q.pixel_format};
			REG_COLOR:  prdata = {16'd0, cfg_q.fill_color};
			REG_BLEND:  prdata = {24'd0, cfg_q.global_blend};
			default:    prdata = 32'd0;
		endcase
	end

	// The pipeline advances as a whole when the output register is free or drained.
	assign en       = !v_s4 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s4;
	assign m_tdata  = pix_s4;

	cpb_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.old_pixel (s_tdata[15:0]),
		.coverage  (s_tdata[23:16]),
		.cfg       (cfg_q),
		.st_s2     (st_s2)
	);

	cpb_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.st_s2  (st_s2),
		.cfg    (cfg_q),
		.v_s4   (v_s4),
		.pix_s4 (pix_s4)
	);

endmodule

// ===== sv/cpb_checker.sv =====
`timescale 1ns / 1ps
module cpb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output register");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("transfer did not reach the output in four cycles");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready && !$isunknown(s_tready))
		else $error("configuration port or input ready misbehaved");

endmodule

bind coverage_pixel_blend cpb_checker u_cpb_checker (.*);

// ===== dv/cpb_blend_checker.sv =====
`timescale 1ns / 1ps
module cpb_blend_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // old_pixel [15:0], coverage [23:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // new_pixel [15:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);
	import cpb_pkg::*;

	logic [1:0]  cur_format;
	logic [15:0] cur_color;
	logic [7:0]  cur_level;
	logic [15:0] expected_pixels[$];
	logic [15:0] want;

	initial errors = 0;

	function automatic logic [15:0] blend_pixel(
		input logic [1:0]  fmt,
		input logic [15:0] color,
		input logic [7:0]  level,
		input logic [15:0] old,
		input logic [7:0]  cov
	);
		logic        opaque;
		logic [15:0] prod;
		logic [4:0]  w;
		logic [7:0]  c;
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] s;
		logic [31:0] d;
		logic [31:0] t;
		logic [31:0] acc;
		opaque = (level == BLEND_OPAQUE);
		prod = cov * level;
		w = opaque ? cov[7:3] : prod[15:11];
		c = opaque ? cov : prod[15:8];
		case (fmt)
			FMT_RGB_LE, FMT_RGB_BE: begin
				if (opaque && cov == COV_FULL)
					return color;
				src = (fmt == FMT_RGB_BE) ? {color[7:0], color[15:8]} : color;
				dst = (fmt == FMT_RGB_BE) ? {old[7:0], old[15:8]} : old;
				s = {src, src} & PACK_MASK;
				d = {dst, dst} & PACK_MASK;
				t = {27'd0, w} * (s - d) + (d << 5) - d + PACK_ROUND;
				t = t + ((t >> 5) & PACK_MASK);
				t = (t >> 5) & PACK_MASK;
				t = t | (t >> 16);
				return (fmt == FMT_RGB_BE) ? {t[7:0], t[15:8]} : t[15:0];
			end
			FMT_GRAY4: begin
				if (opaque && cov == COV_FULL)
					return {12'd0, color[3:0]};
				acc = old[3:0] * (COV_FULL - c) + color[3:0] * c;
				return acc[23:8];
			end
			default: begin
				if (opaque && w == W_FULL)
					return {8'd0, color[7:0]};
				acc = old[7:0] * (W_FULL - w) + color[7:0] * w;
				return acc[20:5];
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] exp_val);
		$display("MISMATCH at %0t: %s, got %h, expected %h", $realtime, what, got, exp_val);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_format <= FMT_RGB_LE;
			cur_color  <= 16'h0000;
			cur_level  <= BLEND_OPAQUE;
			expected_pixels.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("result transfer with no pixel pending", m_tdata, 16'h0000);
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata !== want)
						report_mismatch("new_pixel", m_tdata, want);
				end
			end
			if (s_tvalid && s_tready)
				expected_pixels.push_back(blend_pixel(cur_format, cur_color, cur_level,
					s_tdata[15:0], s_tdata[23:16]));
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_FORMAT: cur_format <= pwdata[1:0];
					REG_COLOR:  cur_color  <= pwdata[15:0];
					REG_BLEND:  cur_level  <= pwdata[7:0];
					default: ;
				endcase
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

// ===== dv/tb_coverage_pixel_blend.sv =====
`timescale 1ns / 1ps
module tb_coverage_pixel_blend;
	import cpb_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // old_pixel [15:0], coverage [23:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // new_pixel [15:0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          cycles;
	bit          calm;

	coverage_pixel_blend i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	cpb_blend_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] fmt_word, input logic [31:0] color_word,
			input logic [31:0] level_word);
		apb_write(REG_FORMAT, fmt_word);
		apb_write(REG_COLOR, color_word);
		apb_write(REG_BLEND, level_word);
		apb_release();
	endtask

	task automatic send_pixel(input logic [15:0] old, input logic [7:0] cov);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {cov, old};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		logic [7:0]  levels[3];
		logic [31:0] fmt_word;
		logic [31:0] level_word;
		logic [31:0] pix_word;
		logic [15:0] color;
		logic [7:0]  cov;
		int          fi;
		int          li;
		int          phase;
		int          n;
		levels = '{BLEND_OPAQUE, 8'h00, 8'h80};
		calm = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write to the unused address must leave the reset settings in place.
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		apb_release();
		send_pixel(16'hFFFF, COV_FULL);
		send_pixel(16'hFFFF, 8'h00);
		wait_for_results();

		for (fi = 0; fi < 4; fi++) begin
			for (li = 0; li < 3; li++) begin
				color = (fi % 2 == 1) ? 16'h0000 : 16'hFFFF;
				set_config(fi, {16'h0000, color}, {24'h000000, levels[li]});
				send_pixel(~color, COV_FULL);
				send_pixel(~color, 8'h00);
				wait_for_results();
			end
		end

		for (phase = 0; phase < 10; phase++) begin
			calm = (phase == 4 || phase == 9);
			fmt_word = $urandom;
			fmt_word[1:0] = phase[1:0];
			level_word = $urandom;
			case ($urandom_range(0, 4))
				0, 1: level_word[7:0] = BLEND_OPAQUE;
				2: level_word[7:0] = 8'h00;
				3: level_word[7:0] = 8'hFE;
				default: level_word[7:0] = 8'($urandom_range(1, 254));
			endcase
			set_config(fmt_word, $urandom, level_word);
			for (n = 0; n < 50; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: cov = COV_FULL;
					3: cov = 8'h00;
					4: cov = 8'hF8;
					default: cov = 8'($urandom_range(0, 255));
				endcase
				pix_word = $urandom;
				send_pixel(pix_word[15:0], cov);
			end
			wait_for_results();
		end

		if (errors == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/cpb_pkg.sv
sv/cpb_weight.sv
sv/cpb_mix.sv
sv/coverage_pixel_blend.sv
sv/cpb_checker.sv
dv/cpb_blend_checker.sv
dv/tb_coverage_pixel_blend.sv
